[src/jacobi_linear_solver_top_defines.svh]
// assertion macros used by the solver datapath
`ifndef JACOBI_LINEAR_SOLVER_TOP_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define JLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("jls check failed");
// antecedent implies consequent in the next cycle
`define JLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jls sequence check failed");
`else
`define JLS_ASSERT(lbl, prop)
`define JLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/jls_pkg.sv]
`timescale 1ns / 1ps
package jls_pkg;

  localparam int SIZE_N = 64;
  localparam int IDX_W  = 6;
  localparam int ACC_W  = 56;
  localparam int NUM_W  = 57;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_SOLVE  = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG, S_DIAG_WAIT, S_DIAG_CHK, S_ACC, S_DRAIN1, S_DRAIN2,
    S_DIV_START, S_DIV_WAIT, S_SWEEP_END, S_EMIT_RD, S_EMIT_LD
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_A, OP_LOAD_B, OP_CLEAR, OP_DIAG_RD, OP_ACC,
    OP_DIV_START, OP_WRITE, OP_SWEEP_END, OP_EMIT_RD, OP_EMIT_LD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [1:0]       status;
    logic [15:0]      iters;
  } cmd_t;

  typedef struct packed {
    logic zero_diag;
    logic div_done;
    logic big_le_tol;
    logic out_free;
  } sts_t;

endpackage

[src/jls_ram.sv]
`timescale 1ns / 1ps
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/jls_div.sv]
`timescale 1ns / 1ps
module jls_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [jls_pkg::NUM_W-1:0] num,
  input  logic signed [31:0]               den,
  output logic                             done,
  output logic signed [31:0]               quo
);
  import jls_pkg::*;

  logic [NUM_W-2:0] un;
  logic [31:0]      ud;
  logic             ovf_now;
  logic             busy;
  logic [5:0]       cnt;
  logic [31:0]      rem;
  logic [31:0]      strm;
  logic [31:0]      q;
  logic             neg;
  logic             ovf;
  logic [32:0]      t;
  logic             ge;

  assign un      = num[NUM_W-1] ? (NUM_W-1)'(-num) : num[NUM_W-2:0];
  assign ud      = den[31] ? 32'(-den) : den;
  assign ovf_now = un[NUM_W-2:16] >= {8'b0, ud};
  assign t       = {rem, strm[31]};
  assign ge      = t >= {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        neg  <= num[NUM_W-1] ^ den[31];
        ovf  <= ovf_now;
        rem  <= ovf_now ? 32'd0 : un[47:16];
        strm <= {un[15:0], 16'b0};
        q    <= '0;
      end else if (busy) begin
        rem  <= ge ? 32'(t - {1'b0, ud}) : t[31:0];
        strm <= {strm[30:0], 1'b0};
        q    <= {q[30:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round toward zero, then saturate
  always_comb begin
    if (ovf) begin
      quo = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg) begin
      quo = q[31] ? 32'sh8000_0000 : -$signed(q);
    end else begin
      quo = q[31] ? 32'sh7fff_ffff : $signed(q);
    end
  end

endmodule

[src/jls_datapath.sv]
`timescale 1ns / 1ps
`include "jacobi_linear_solver_top_defines.svh"
module jls_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  jls_pkg::cmd_t                    cmd,
  output jls_pkg::sts_t                    sts,
  input  logic [jls_pkg::IDX_W-1:0]        row,
  input  logic [jls_pkg::IDX_W-1:0]        col,
  input  logic signed [31:0]               value,
  input  logic [30:0]                      tolerance,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [jls_pkg::IDX_W-1:0]        index,
  output logic signed [31:0]               solution,
  output logic                             last,
  output logic [1:0]                       status,
  output logic [15:0]                      iterations
);
  import jls_pkg::*;

  logic [2*IDX_W-1:0]      a_raddr;
  logic                    a_re;
  logic signed [31:0]      a_rd;
  logic                    b_re;
  logic signed [31:0]      b_rd;
  logic                    x_re;
  logic [IDX_W-1:0]        x_raddr;
  logic                    x_we;
  logic signed [31:0]      x0_rd;
  logic signed [31:0]      x1_rd;
  logic signed [31:0]      x_prev;
  logic                    sel;
  logic                    xz;
  logic                    dv;
  logic                    zflag;
  logic                    v1;
  logic                    v2;
  logic [IDX_W-1:0]        i1;
  logic [IDX_W-1:0]        j1;
  logic                    skip2;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      dreg;
  logic signed [31:0]      breg;
  logic signed [NUM_W-1:0] num;
  logic                    div_done;
  logic signed [31:0]      div_res;
  logic signed [32:0]      delta;
  logic [31:0]             mag;
  logic [31:0]             big;

  assign a_re    = (cmd.op == OP_DIAG_RD) || (cmd.op == OP_ACC);
  assign a_raddr = (cmd.op == OP_DIAG_RD) ? {cmd.i, cmd.i} : {cmd.i, cmd.j};
  assign b_re    = (cmd.op == OP_ACC) && (cmd.j == '0);
  assign x_re    = (cmd.op == OP_ACC) || (cmd.op == OP_DIV_START) ||
                   (cmd.op == OP_EMIT_RD);
  assign x_raddr = (cmd.op == OP_ACC) ? cmd.j : cmd.i;
  assign x_we    = cmd.op == OP_WRITE;

  jls_ram #(.WIDTH(32), .DEPTH(SIZE_N * SIZE_N)) u_a_ram (
    .clk(clk), .we(cmd.op == OP_LOAD_A), .waddr({row, col}), .wdata(value),
    .re(a_re), .raddr(a_raddr), .rdata(a_rd)
  );

  jls_ram #(.WIDTH(32), .DEPTH(SIZE_N)) u_b_ram (
    .clk(clk), .we(cmd.op == OP_LOAD_B), .waddr(row), .wdata(value),
    .re(b_re), .raddr(cmd.i), .rdata(b_rd)
  );

  // ping-pong banks: sel names the bank holding the previous sweep
  jls_ram #(.WIDTH(32), .DEPTH(SIZE_N)) u_x0_ram (
    .clk(clk), .we(x_we && sel), .waddr(cmd.i), .wdata(div_res),
    .re(x_re), .raddr(x_raddr), .rdata(x0_rd)
  );

  jls_ram #(.WIDTH(32), .DEPTH(SIZE_N)) u_x1_ram (
    .clk(clk), .we(x_we && !sel), .waddr(cmd.i), .wdata(div_res),
    .re(x_re), .raddr(x_raddr), .rdata(x1_rd)
  );

  // x reads as zero until the first sweep completes
  assign x_prev = xz ? 32'sd0 : (sel ? x1_rd : x0_rd);

  assign num = NUM_W'(breg) - NUM_W'(acc);

  jls_div u_div (
    .clk(clk), .rst(rst), .start(cmd.op == OP_DIV_START), .num(num),
    .den(dreg), .done(div_done), .quo(div_res)
  );

  assign delta = 33'(div_res) - 33'(x_prev);
  assign mag   = delta[32] ? 32'(-delta) : delta[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      xz        <= 1'b1;
      dv        <= 1'b0;
      zflag     <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv <= cmd.op == OP_DIAG_RD;
      v1 <= cmd.op == OP_ACC;
      v2 <= v1;
      if (cmd.op == OP_CLEAR) begin
        xz    <= 1'b1;
        zflag <= 1'b0;
      end else if (dv && (a_rd == 32'sd0)) begin
        zflag <= 1'b1;
      end
      if (cmd.op == OP_SWEEP_END) begin
        sel <= !sel;
        xz  <= 1'b0;
      end
      if (cmd.op == OP_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i1 <= cmd.i;
    j1 <= cmd.j;
    if (v1) begin
      prod  <= a_rd * x_prev;
      skip2 <= j1 == i1;
      if (j1 == i1) begin
        dreg <= a_rd;
      end
      if (j1 == '0) begin
        breg <= b_rd;
      end
    end
    // arithmetic shift floors the product to q16.16
    if ((cmd.op == OP_ACC) && (cmd.j == '0)) begin
      acc <= '0;
    end else if (v2 && !skip2) begin
      acc <= acc + ACC_W'(prod >>> 16);
    end
    if ((cmd.op == OP_ACC) && (cmd.i == '0) && (cmd.j == '0)) begin
      big <= '0;
    end else if ((cmd.op == OP_WRITE) && (mag > big)) begin
      big <= mag;
    end
    if (cmd.op == OP_EMIT_LD) begin
      index      <= cmd.i;
      solution   <= x_prev;
      last       <= cmd.i == IDX_W'(SIZE_N - 1);
      status     <= cmd.status;
      iterations <= cmd.iters;
    end
  end

  assign sts.zero_diag  = zflag;
  assign sts.div_done   = div_done;
  assign sts.big_le_tol = big <= {1'b0, tolerance};
  assign sts.out_free   = !out_valid || !out_stall;

  `JLS_ASSERT(a_emit_free, (cmd.op != OP_EMIT_LD) || !out_valid)
  `JLS_ASSERT(a_write_done, (cmd.op != OP_WRITE) || div_done)
  `JLS_ASSERT(a_div_drained, (cmd.op != OP_DIV_START) || (!v1 && !v2))
  `JLS_ASSERT_NEXT(a_end_clears_xz, cmd.op == OP_SWEEP_END, !xz)

endmodule

[src/jls_ctrl.sv]
`timescale 1ns / 1ps
module jls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [15:0]         max_iterations,
  input  jls_pkg::sts_t       sts,
  output jls_pkg::cmd_t       cmd
);
  import jls_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIZE_N - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [15:0]      cnt, cnt_next;
  logic [1:0]       st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      cnt   <= '0;
      st    <= ST_CONVERGED;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      cnt   <= cnt_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    cnt_next   = cnt;
    st_next    = st;
    in_stall   = 1'b1;
    cmd.op     = OP_NONE;
    cmd.i      = i;
    cmd.j      = j;
    cmd.status = st;
    cmd.iters  = cnt;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (action)
            ACT_LOAD_A: cmd.op = OP_LOAD_A;
            ACT_LOAD_B: cmd.op = OP_LOAD_B;
            ACT_SOLVE: begin
              cmd.op     = OP_CLEAR;
              i_next     = '0;
              cnt_next   = '0;
              state_next = S_DIAG;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_DIAG: begin
        cmd.op = OP_DIAG_RD;
        i_next = i + 1'b1;
        if (i == LAST_IDX) begin
          state_next = S_DIAG_WAIT;
        end
      end
      S_DIAG_WAIT: state_next = S_DIAG_CHK;
      S_DIAG_CHK: begin
        i_next = '0;
        j_next = '0;
        if (sts.zero_diag) begin
          st_next    = ST_ZERO_DIAG;
          state_next = S_EMIT_RD;
        end else if (max_iterations == 16'd0) begin
          st_next    = ST_LIMIT;
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        j_next = j + 1'b1;
        if (j == LAST_IDX) begin
          state_next = S_DRAIN1;
        end
      end
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_DIV_START;
      S_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.op = OP_WRITE;
          i_next = i + 1'b1;
          state_next = (i == LAST_IDX) ? S_SWEEP_END : S_ACC;
        end
      end
      S_SWEEP_END: begin
        cmd.op   = OP_SWEEP_END;
        cnt_next = cnt + 16'd1;
        i_next   = '0;
        if (sts.big_le_tol) begin
          st_next    = ST_CONVERGED;
          state_next = S_EMIT_RD;
        end else if (({1'b0, cnt} + 17'd1) >= {1'b0, max_iterations}) begin
          st_next    = ST_LIMIT;
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_ACC;
        end
      end
      S_EMIT_RD: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_RD;
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.op = OP_EMIT_LD;
        i_next = i + 1'b1;
        state_next = (i == LAST_IDX) ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/jacobi_linear_solver_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           beat
// in        input      in_valid/in_stall   action, row, col, value
// out       output     out_valid/out_stall index, solution, last, status, iterations
// cfg       apb        psel/penable/pready tolerance at 0x0, max_iterations at 0x4
//
// load beats take one cycle each and are accepted back to back while idle
// a solve first checks the 64 diagonal entries for zero, then for each row
// of each sweep makes 64 multiply-accumulate reads of the matrix ram and
// runs a 32-step serial divide; each result is read, then loaded to out
// input is stalled from a solve beat until its last result is registered
// synchronous reset clears control state; stores are undefined until loaded
module jacobi_linear_solver_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [jls_pkg::IDX_W-1:0]    row,
  input  logic [jls_pkg::IDX_W-1:0]    col,
  input  logic signed [31:0]           value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [jls_pkg::IDX_W-1:0]    index,
  output logic signed [31:0]           solution,
  output logic                         last,
  output logic [1:0]                   status,
  output logic [15:0]                  iterations,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import jls_pkg::*;

  logic [30:0] tolerance;
  logic [15:0] max_iterations;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'b0, max_iterations} : {1'b0, tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= 31'd1;
      max_iterations <= 16'd10000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        max_iterations <= pwdata[15:0];
      end else begin
        tolerance <= pwdata[30:0];
      end
    end
  end

  jls_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .max_iterations(max_iterations), .sts(sts), .cmd(cmd)
  );

  jls_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .row(row), .col(col),
    .value(value), .tolerance(tolerance), .out_valid(out_valid),
    .out_stall(out_stall), .index(index), .solution(solution), .last(last),
    .status(status), .iterations(iterations)
  );

endmodule
